// ===== hw/rtl/bphtp_pkg.sv =====
package bphtp_pkg;

  // Hop writes carried by one accepted bind packet.
  localparam int unsigned HopsPerPkt = 5;
  // Shortest packet that can be a bind packet.
  localparam logic [7:0] MinPacket = 8'd18;
  // Depth of the queue between the packet parser and the result sequencer.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  // Configuration register indexes.
  localparam logic [7:0] RegBindMarker = 8'd0;
  localparam logic [7:0] RegFinalIndex = 8'd1;

  // Packed widths of the stream payloads.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  // One classified packet, ready to be turned into results.
  typedef struct packed {
    logic [15:0]                     tx_id;
    logic [6:0]                      idx;
    logic [HopsPerPkt-1:0][7:0]      ch;
    logic [2:0]                      count;     // hop writes before the end marker
    logic                            marker;    // end marker found in this packet
    logic                            done;      // binding ends after the fifth write
    logic [6:0]                      list_len;
  } job_t;

endpackage

// ===== hw/rtl/bphtp_front.sv =====
module bphtp_front #(
  parameter int unsigned MaxPacket = 127
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic               restart_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               last_byte_i,
  input  logic [7:0]         bind_marker_i,
  input  logic [6:0]         final_index_i,
  output logic               push_o,
  output bphtp_pkg::job_t    job_o
);
  import bphtp_pkg::*;

  localparam logic [1:0] PhWait    = 2'd0;
  localparam logic [1:0] PhCollect = 2'd1;
  localparam logic [1:0] PhDone    = 2'd2;
  localparam logic [7:0] MaxLen    = 8'(MaxPacket);

  logic [7:0]  byte_count_q, byte_count_d;
  logic [7:0]  hdr_q [9];
  logic [7:0]  tail_q [2];   // index 0: previous byte, index 1: the one before
  logic [1:0]  phase_q, phase_d;
  logic [6:0]  exp_idx_q, exp_idx_d;
  logic [15:0] tx_id_q, tx_id_d;

  logic [7:0]  len;
  logic        first;
  logic [15:0] pkt_id;
  logic        pkt_ok;
  logic [7:0]  next_idx;
  logic        mark_hit;
  logic [2:0]  mark_pos;
  logic [6:0]  idx7;
  logic        hdr_wr;
  logic [7:0]  hdr_off;

  // Packet length including the current byte, saturating.
  assign len      = (byte_count_q == 8'hFF) ? 8'hFF : byte_count_q + 8'd1;
  assign first    = (phase_q == PhWait);
  assign pkt_id   = {hdr_q[1], hdr_q[2]};
  assign idx7     = hdr_q[3][6:0];
  assign next_idx = {1'b0, idx7} + 8'(HopsPerPkt);
  assign hdr_wr   = (byte_count_q >= 8'd2) && (byte_count_q <= 8'd10);
  assign hdr_off  = byte_count_q - 8'd2;

  // Packet checks on its final byte.
  always_comb begin
    pkt_ok = (phase_q != PhDone) && (len >= MinPacket) && (len <= MaxLen) &&
             rx_byte_i[7] && (hdr_q[0] == bind_marker_i);
    if (first) begin
      pkt_ok = pkt_ok && (hdr_q[3] == 8'd0);
    end else begin
      pkt_ok = pkt_ok && (pkt_id == tx_id_q) && (hdr_q[3] == {1'b0, exp_idx_q});
    end
  end

  // End-of-list search: first channel equal to the byte three from the end.
  always_comb begin
    mark_hit = 1'b0;
    mark_pos = 3'd0;
    for (int n = HopsPerPkt - 1; n >= 0; n--) begin
      if (!first && (hdr_q[4+n] == tail_q[1])) begin
        mark_hit = 1'b1;
        mark_pos = 3'(n);
      end
    end
  end

  // Next state and the classified packet.
  always_comb begin
    byte_count_d = byte_count_q;
    phase_d      = phase_q;
    exp_idx_d    = exp_idx_q;
    tx_id_d      = tx_id_q;
    push_o       = 1'b0;

    job_o.tx_id    = first ? pkt_id : tx_id_q;
    job_o.idx      = idx7;
    for (int n = 0; n < HopsPerPkt; n++) begin
      job_o.ch[n] = hdr_q[4+n];
    end
    job_o.count    = mark_hit ? mark_pos : 3'(HopsPerPkt);
    job_o.marker   = mark_hit;
    job_o.done     = next_idx > {1'b0, final_index_i};
    job_o.list_len = mark_hit ? idx7 + 7'(mark_pos) : 7'd0;

    if (byte_valid_i) begin
      if (restart_i) begin
        byte_count_d = 8'd0;
        phase_d      = PhWait;
        exp_idx_d    = 7'd0;
        tx_id_d      = 16'd0;
      end else if (last_byte_i) begin
        byte_count_d = 8'd0;
        if (pkt_ok) begin
          push_o = 1'b1;
          if (first) begin
            tx_id_d = pkt_id;
          end
          if (mark_hit || job_o.done) begin
            phase_d = PhDone;
          end else begin
            phase_d   = PhCollect;
            exp_idx_d = next_idx[6:0];
          end
        end
      end else begin
        byte_count_d = len;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 8'd0;
      phase_q      <= PhWait;
      exp_idx_q    <= 7'd0;
      tx_id_q      <= 16'd0;
    end else begin
      byte_count_q <= byte_count_d;
      phase_q      <= phase_d;
      exp_idx_q    <= exp_idx_d;
      tx_id_q      <= tx_id_d;
    end
  end

  // Header bytes and the short tail history.
  always_ff @(posedge clk_i) begin
    if (byte_valid_i && !restart_i) begin
      if (hdr_wr) begin
        hdr_q[hdr_off[3:0]] <= rx_byte_i;
      end
      tail_q[1] <= tail_q[0];
      tail_q[0] <= rx_byte_i;
    end
  end

endmodule

// ===== hw/rtl/bphtp_queue.sv =====
module bphtp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bphtp_pkg::job_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bphtp_pkg::job_t head_o
);
  import bphtp_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   fill_q;

  assign full_o  = (fill_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/bphtp_back.sv =====
module bphtp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  bphtp_pkg::job_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            hop_valid_o,
  output logic [6:0]      hop_index_o,
  output logic [7:0]      hop_channel_o,
  output logic [15:0]     tx_id_o,
  output logic            bind_done_o,
  output logic [6:0]      list_length_o,
  output logic            last_o
);
  import bphtp_pkg::*;

  logic [2:0]  n_q;
  logic        out_valid_q;
  logic        hop_valid_q, done_q, last_q;
  logic [6:0]  hop_index_q, list_len_q;
  logic [7:0]  hop_channel_q;
  logic [15:0] tx_id_q;

  logic        load;
  logic        is_write;
  logic        res_last;

  assign load     = !out_valid_q || out_ready_i;
  assign is_write = n_q < head_i.count;
  assign res_last = is_write ? (!head_i.marker && (n_q == 3'(HopsPerPkt - 1))) : 1'b1;
  assign pop_o    = load && !empty_i && res_last;

  // Result step counter within the head packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (!empty_i) begin
        n_q <= res_last ? 3'd0 : n_q + 3'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      hop_valid_q   <= is_write;
      hop_index_q   <= is_write ? head_i.idx + 7'(n_q) : 7'd0;
      hop_channel_q <= is_write ? head_i.ch[n_q] : 8'd0;
      tx_id_q       <= head_i.tx_id;
      done_q        <= is_write ? (res_last && head_i.done) : 1'b1;
      list_len_q    <= is_write ? 7'd0 : head_i.list_len;
      last_q        <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hop_valid_o   = hop_valid_q;
  assign hop_index_o   = hop_index_q;
  assign hop_channel_o = hop_channel_q;
  assign tx_id_o       = tx_id_q;
  assign bind_done_o   = done_q;
  assign list_length_o = list_len_q;
  assign last_o        = last_q;

endmodule

// ===== hw/rtl/bind_packet_hop_table_parser.sv =====
// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid_i/tready_o     tdata rx_byte, tuser operation, tlast last_byte
// m_axis   out        m_axis_tvalid_o/tready_i     tdata hop fields, tuser hop_valid, tlast last
// cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One byte is taken per cycle; a packet's hop writes leave one per cycle
// through the output register while m_axis_tready_i does not hold it, up to five per packet, set by the sequencer.
// The parser stalls only when the four-entry packet queue is full.
// Reset clears the parser state and the queue; registers return to defaults.
// The configuration port is always ready.
module bind_packet_hop_table_parser #(
  parameter int unsigned MAX_PACKET = 127
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [bphtp_pkg::InDataW-1:0]     s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                              s_axis_tuser_i,   // [0] operation
  input  logic                              s_axis_tlast_i,   // last_byte
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [6:0] hop_index, [14:7] hop_channel, [30:15] tx_id, [31] bind_done,
  // [38:32] list_length, [39] zero
  output logic [bphtp_pkg::OutDataW-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tuser_o,   // [0] hop_valid
  output logic                              m_axis_tlast_o,   // last
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [7:0]                        cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);
  import bphtp_pkg::*;

  logic [7:0]  bind_marker_q;
  logic [6:0]  final_index_q;
  logic        full, empty, push, pop, byte_valid;
  job_t        push_job, head_job;
  logic        hop_valid, bind_done;
  logic [6:0]  hop_index, list_length;
  logic [7:0]  hop_channel;
  logic [15:0] tx_id;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bind_marker_q <= 8'd1;
      final_index_q <= 7'd120;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegBindMarker: bind_marker_q <= cfg_data_i;
        RegFinalIndex: final_index_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !full;
  assign byte_valid      = s_axis_tvalid_i && !full;

  bphtp_front #(
    .MaxPacket(MAX_PACKET)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_valid),
    .restart_i     (s_axis_tuser_i),
    .rx_byte_i     (s_axis_tdata_i),
    .last_byte_i   (s_axis_tlast_i),
    .bind_marker_i (bind_marker_q),
    .final_index_i (final_index_q),
    .push_o        (push),
    .job_o         (push_job)
  );

  bphtp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_job)
  );

  bphtp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_job),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .hop_valid_o   (hop_valid),
    .hop_index_o   (hop_index),
    .hop_channel_o (hop_channel),
    .tx_id_o       (tx_id),
    .bind_done_o   (bind_done),
    .list_length_o (list_length),
    .last_o        (m_axis_tlast_o)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = {1'b0, list_length, bind_done, tx_id, hop_channel, hop_index};
  assign m_axis_tuser_o = hop_valid;

endmodule
